// ===== design/debounced_pin_edge_rule_matcher_assert.svh =====
// assertion macros used by the top-level design file
`ifndef DEBOUNCED_PIN_EDGE_RULE_MATCHER_ASSERT_SVH
`define DEBOUNCED_PIN_EDGE_RULE_MATCHER_ASSERT_SVH

// condition holds in the same cycle as its trigger
`define DPE_ASSERT_NOW(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("same-cycle check failed");

// condition holds in the cycle after its trigger
`define DPE_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("next-cycle check failed");

`endif

// ===== design/dpe_pkg.sv =====
`timescale 1ns / 1ps

package dpe_pkg;

    // default geometry
    localparam int NUM_PORTS_DEF     = 4;
    localparam int PINS_PER_PORT_DEF = 8;
    localparam int NUM_RULES_DEF     = 8;

    // the rule registers describe at most this many rules
    localparam int REG_RULE_LIMIT = 8;

    // stream widths
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_RULE_COUNT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RULE_PORTS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RULE_PINS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RULE_RISING    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HANDLER_PORT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HANDLER_ENABLE = 3'd5;

    typedef struct packed {
        logic [3:0]  rule_count;
        logic [15:0] rule_ports;
        logic [23:0] rule_pins;
        logic [7:0]  rule_rising;
        logic [1:0]  handler_port;
        logic        handler_enable;
    } t_rule_cfg;

    typedef struct packed {
        logic       hit;
        logic [2:0] rule;
        logic [2:0] pin;
    } t_match;

endpackage

// ===== design/dpe_cfg_regs.sv =====
`timescale 1ns / 1ps

module dpe_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dpe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dpe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output dpe_pkg::t_rule_cfg            o_cfg
);
    import dpe_pkg::*;

    t_rule_cfg r_cfg;
    t_rule_cfg n_cfg;

    // register write decode, unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RULE_COUNT:     n_cfg.rule_count     = i_cfg_data[3:0];
                CFG_RULE_PORTS:     n_cfg.rule_ports     = i_cfg_data[15:0];
                CFG_RULE_PINS:      n_cfg.rule_pins      = i_cfg_data[23:0];
                CFG_RULE_RISING:    n_cfg.rule_rising    = i_cfg_data[7:0];
                CFG_HANDLER_PORT:   n_cfg.handler_port   = i_cfg_data[1:0];
                CFG_HANDLER_ENABLE: n_cfg.handler_enable = i_cfg_data[0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg                <= '0;
            r_cfg.handler_enable <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/dpe_port.sv =====
`timescale 1ns / 1ps

module dpe_port #(
    parameter int PINS = dpe_pkg::PINS_PER_PORT_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic [PINS-1:0] i_sample,
    input  logic            i_fire,
    input  logic [2:0]      i_fire_pin,
    output logic [PINS-1:0] o_deb_next,
    output logic [PINS-1:0] o_ack
);
    import dpe_pkg::*;

    logic [PINS-1:0] r_prev;
    logic [PINS-1:0] r_deb;
    logic [PINS-1:0] r_ack;
    logic [PINS-1:0] n_deb;
    logic [PINS-1:0] n_ack;
    logic [PINS-1:0] fire_mask;

    // two equal samples in a row set the debounced level
    assign n_deb = (r_prev == i_sample) ? i_sample : r_deb;

    // one-hot mask of the pin that fired
    always_comb begin
        for (int b = 0; b < PINS; b++) begin
            fire_mask[b] = (i_fire_pin == 3'(b));
        end
    end

    // a fired rule acknowledges only its pin, otherwise everything is taken
    assign n_ack = i_fire ? ((r_ack & ~fire_mask) | (n_deb & fire_mask)) : n_deb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_deb  <= '0;
            r_ack  <= '0;
        end else if (i_step) begin
            r_prev <= i_sample;
            r_deb  <= n_deb;
            r_ack  <= n_ack;
        end
    end

    assign o_deb_next = n_deb;
    assign o_ack      = r_ack;

endmodule

// ===== design/dpe_rule_match.sv =====
`timescale 1ns / 1ps

module dpe_rule_match #(
    parameter int NUM_RULES     = dpe_pkg::NUM_RULES_DEF,
    parameter int PINS_PER_PORT = dpe_pkg::PINS_PER_PORT_DEF
) (
    input  dpe_pkg::t_rule_cfg i_cfg,
    input  logic [7:0]         i_deb,
    input  logic [7:0]         i_ack,
    output dpe_pkg::t_match    o_match
);
    import dpe_pkg::*;

    // priority scan, lowest rule index wins
    always_comb begin
        int         limit;
        logic       found;
        logic [1:0] rport;
        logic [2:0] rpin;
        logic       rising;
        logic       is_edge;
        limit = int'(i_cfg.rule_count);
        if (limit > NUM_RULES) limit = NUM_RULES;
        if (limit > REG_RULE_LIMIT) limit = REG_RULE_LIMIT;
        found   = 1'b0;
        o_match = '0;
        for (int i = 0; i < REG_RULE_LIMIT; i++) begin
            rport   = i_cfg.rule_ports[2*i +: 2];
            rpin    = i_cfg.rule_pins[3*i +: 3];
            rising  = i_cfg.rule_rising[i];
            is_edge = rising ? (!i_ack[rpin] && i_deb[rpin]) : (i_ack[rpin] && !i_deb[rpin]);
            if (!found && (i < limit) && (rport == i_cfg.handler_port)
                    && (int'(rpin) < PINS_PER_PORT) && is_edge) begin
                found        = 1'b1;
                o_match.hit  = 1'b1;
                o_match.rule = 3'(i);
                o_match.pin  = rpin;
            end
        end
    end

endmodule

// ===== design/debounced_pin_edge_rule_matcher.sv =====
`timescale 1ns / 1ps

// Debounced pin edge rule matcher. Each input item carries one raw sample of
// all pin ports (port 0 in the low byte); each item produces exactly one result
// item with the debounced levels after that tick and the rule event, if any.
// A port takes a new debounced level when two consecutive samples agree. On the
// handler port, the first enabled rule whose pin shows its configured edge
// fires and only that pin is acknowledged; other changes stay pending. The
// block accepts one item per clock cycle while the output is not stalled. An
// item is taken into the input register when it is accepted, and its result is
// loaded into the result register when the item advances, which waits while
// the output is stalled; the result can be taken from then on. The rate is set
// by the single pass from the input register through the per-port state update
// and the eight-entry rule priority scan into the result register.
// Configuration writes are taken at any cycle but are meant for an idle block.
module debounced_pin_edge_rule_matcher #(
    parameter int NUM_PORTS     = dpe_pkg::NUM_PORTS_DEF,
    parameter int PINS_PER_PORT = dpe_pkg::PINS_PER_PORT_DEF,
    parameter int NUM_RULES     = dpe_pkg::NUM_RULES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dpe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dpe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // pin_samples[31:0]
    input  logic [dpe_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // debounced_pins[31:0], event_fired[32], event_rule[35:33], event_pin[38:36], zero[39]
    output logic [dpe_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import dpe_pkg::*;

    `include "debounced_pin_edge_rule_matcher_assert.svh"

    t_rule_cfg cfg;
    t_match    match;

    logic                   r_in_valid;
    logic [S_TDATA_W-1:0]   r_in_data;
    logic                   r_out_valid;
    logic [M_TDATA_W-1:0]   r_out_data;
    logic                   advance;
    logic                   handler_ok;
    logic                   fire;
    logic [7:0]             sel_deb;
    logic [7:0]             sel_ack;
    logic [31:0]            n_deb_pins;
    logic [M_TDATA_W-1:0]   n_out_data;

    logic [PINS_PER_PORT-1:0] deb_next [NUM_PORTS];
    logic [PINS_PER_PORT-1:0] ack      [NUM_PORTS];

    // configuration registers
    dpe_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // pipeline handshake
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata;
        end
    end

    // per-port debounce and acknowledge state
    for (genvar p = 0; p < NUM_PORTS; p++) begin : g_port
        logic [PINS_PER_PORT-1:0] sample;
        logic                     is_handler;

        if (p < 4) begin : g_in
            assign sample = r_in_data[8*p +: PINS_PER_PORT];
        end else begin : g_zero
            assign sample = '0;
        end

        assign is_handler = cfg.handler_enable && (int'(cfg.handler_port) == p);

        dpe_port #(
            .PINS (PINS_PER_PORT)
        ) u_port (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_step     (advance),
            .i_sample   (sample),
            .i_fire     (is_handler && match.hit),
            .i_fire_pin (match.pin),
            .o_deb_next (deb_next[p]),
            .o_ack      (ack[p])
        );
    end

    // pick out the handler port's levels
    always_comb begin
        sel_deb = '0;
        sel_ack = '0;
        for (int p = 0; p < NUM_PORTS; p++) begin
            if (int'(cfg.handler_port) == p) begin
                sel_deb = 8'(deb_next[p]);
                sel_ack = 8'(ack[p]);
            end
        end
    end

    assign handler_ok = cfg.handler_enable && (int'(cfg.handler_port) < NUM_PORTS);

    dpe_rule_match #(
        .NUM_RULES     (NUM_RULES),
        .PINS_PER_PORT (PINS_PER_PORT)
    ) u_match (
        .i_cfg   (cfg),
        .i_deb   (sel_deb),
        .i_ack   (sel_ack),
        .o_match (match)
    );

    assign fire = handler_ok && match.hit;

    // result assembly
    always_comb begin
        n_deb_pins = '0;
        for (int p = 0; p < NUM_PORTS && p < 4; p++) begin
            n_deb_pins[8*p +: 8] = 8'(deb_next[p]);
        end
        n_out_data = {1'b0,
                      fire ? match.pin : 3'd0,
                      fire ? match.rule : 3'd0,
                      fire,
                      n_deb_pins};
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // checks
    `DPE_ASSERT_NEXT(a_in_loaded, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, r_in_valid)
    `DPE_ASSERT_NEXT(a_out_loaded, i_clk, i_rst_n, advance, r_out_valid)
    `DPE_ASSERT_NOW(a_no_event_zero, i_clk, i_rst_n, r_out_valid && !r_out_data[32],
        r_out_data[38:33] == 6'd0)
    `DPE_ASSERT_NOW(a_pin_in_port, i_clk, i_rst_n, r_out_valid && r_out_data[32],
        int'(r_out_data[38:36]) < PINS_PER_PORT)

endmodule
